// ----- hw/rtl/elsc_pkg.sv -----
// Package for the light sensor conditioner: field widths, constants and
// the sequencer state type. No dependencies.
`default_nettype none

package elsc_pkg;

  localparam int unsigned SampleW = 12;
  localparam int unsigned WeightW = 16;
  localparam int unsigned LevelW  = 20;
  localparam int unsigned LuxW    = 17;

  // lux = 10^7 * (2F - full scale) / (99 F): 44-bit dividend, 27-bit divisor
  localparam int unsigned NumW = 44;
  localparam int unsigned DenW = 27;
  localparam int unsigned QuoW = LuxW;

  localparam logic [WeightW-1:0] WeightReset = 16'd19661;
  localparam logic [LevelW:0]    FullScaleQ8 = 21'd1048320;
  // dark: 2F <= full scale; bright: 101 F >= 409500*256
  localparam logic [LevelW-1:0]  DarkMax     = 20'd524160;
  localparam logic [LevelW-1:0]  BrightMin   = 20'd1037941;
  localparam logic [LuxW-1:0]    LuxMax      = 17'd100000;
  localparam logic [23:0]        LuxScale    = 24'd10000000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_FIN,
    ST_LUX,
    ST_DIV
  } elsc_state_e;

endpackage

`default_nettype wire

// ----- hw/rtl/elsc_div.sv -----
// Bit-serial restoring divider for the lux estimate, one quotient bit a cycle.
// Depends on elsc_pkg.
`default_nettype none

module elsc_div (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        start_i,
  input  wire  [elsc_pkg::NumW-1:0]  num_i,
  input  wire  [elsc_pkg::DenW-1:0]  den_i,
  output logic                       busy_o,
  output logic [elsc_pkg::QuoW-1:0]  quo_o
);
  import elsc_pkg::*;

  localparam int unsigned CntW = $clog2(QuoW);

  logic            busy_q, busy_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [DenW-1:0] rem_q, rem_d;
  logic [DenW-1:0] den_q, den_d;
  logic [QuoW-1:0] nsr_q, nsr_d;
  logic [QuoW-1:0] quo_q, quo_d;

  logic [DenW:0]   trial;
  logic [DenW+1:0] sub;

  always_comb begin
    trial  = {rem_q, nsr_q[QuoW-1]};
    sub    = {1'b0, trial} - {2'b00, den_q};
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    nsr_d  = nsr_q;
    quo_d  = quo_q;
    if (start_i) begin
      // quotient fits QuoW bits, so the top part of the dividend is below den
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = num_i[NumW-1:QuoW];
      nsr_d  = num_i[QuoW-1:0];
      den_d  = den_i;
    end else if (busy_q) begin
      if (!sub[DenW+1]) begin
        rem_d = sub[DenW-1:0];
        quo_d = {quo_q[QuoW-2:0], 1'b1};
      end else begin
        rem_d = trial[DenW-1:0];
        quo_d = {quo_q[QuoW-2:0], 1'b0};
      end
      nsr_d = {nsr_q[QuoW-2:0], 1'b0};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(QuoW - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    nsr_q <= nsr_d;
    quo_q <= quo_d;
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;

endmodule

`default_nettype wire

// ----- hw/rtl/ewma_light_sensor_conditioner.sv -----
// Light sensor conditioner: EWMA of ADC samples and a lux estimate.
// One sample in flight at a time: a 16-step serial multiply (one weight bit a cycle),
// a 17-step serial divider (one lux bit a cycle) and the FIN, LUX and DIV sequencing
// states run before the next sample is taken; a held-off result beat stalls the input further.
// Reset: history cleared to zero, weight to 19661, output register empty.
// Depends on elsc_pkg and elsc_div.
`default_nettype none

module ewma_light_sensor_conditioner (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire  [elsc_pkg::WeightW-1:0]       cfg_data_i,
  input  wire                                in_valid_i,
  output logic                               in_stall_o,
  input  wire  [elsc_pkg::SampleW-1:0]       adc_sample_i,
  output logic                               out_valid_o,
  input  wire                                out_stall_i,
  output logic [elsc_pkg::LevelW-1:0]        filtered_level_o,
  output logic [elsc_pkg::LuxW-1:0]          light_lux_o
);
  import elsc_pkg::*;

  localparam int unsigned CntW = $clog2(WeightW);

  elsc_state_e state_q, state_d;

  logic [WeightW-1:0]       weight_q, weight_d;
  logic [LevelW-1:0]        hist_q, hist_d;
  logic [WeightW-1:0]       wsr_q, wsr_d;
  logic [CntW-1:0]          cnt_q, cnt_d;
  logic signed [LevelW:0]   diff_q, diff_d;
  logic signed [LevelW+1:0] hi_q, hi_d;
  logic [WeightW-1:0]       lo_q, lo_d;
  logic                     dark_q, dark_d;
  logic                     bright_q, bright_d;
  logic                     out_valid_q, out_valid_d;
  logic [LevelW-1:0]        out_level_q, out_level_d;
  logic [LuxW-1:0]          out_lux_q, out_lux_d;

  logic signed [LevelW+1:0] psum;
  logic signed [LevelW+1:0] fsum;
  logic [LevelW:0]          twice_sub;
  logic [NumW-1:0]          num;
  logic [DenW-1:0]          den;
  logic [DenW-1:0]          lev_ext;
  logic                     div_start;
  logic                     div_busy;
  logic [QuoW-1:0]          div_quo;
  logic                     out_free;

  elsc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num),
    .den_i   (den),
    .busy_o  (div_busy),
    .quo_o   (div_quo)
  );

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    // F = F_prev + (a * (x<<8 - F_prev) + 2^15) >> 16, product built LSB first
    psum      = hi_q + (wsr_q[0] ? {diff_q[LevelW], diff_q} : '0);
    fsum      = $signed({2'b00, hist_q}) + hi_q
              + $signed({{(LevelW+1){1'b0}}, lo_q[WeightW-1]});
    twice_sub = {hist_q, 1'b0} - FullScaleQ8;
    num       = {24'd0, twice_sub[LevelW-1:0]} * {20'd0, LuxScale};
    lev_ext   = {{(DenW-LevelW){1'b0}}, hist_q};
    den       = (lev_ext << 6) + (lev_ext << 5) + (lev_ext << 1) + lev_ext;

    state_d     = state_q;
    weight_d    = weight_q;
    hist_d      = hist_q;
    wsr_d       = wsr_q;
    cnt_d       = cnt_q;
    diff_d      = diff_q;
    hi_d        = hi_q;
    lo_d        = lo_q;
    dark_d      = dark_q;
    bright_d    = bright_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_level_d = out_level_q;
    out_lux_d   = out_lux_q;
    div_start   = 1'b0;
    in_stall_o  = (state_q != ST_IDLE);

    if (cfg_valid_i) begin
      weight_d = cfg_data_i;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          diff_d  = $signed({1'b0, adc_sample_i, 8'd0}) - $signed({1'b0, hist_q});
          wsr_d   = weight_q;
          hi_d    = '0;
          cnt_d   = '0;
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        hi_d  = psum >>> 1;
        lo_d  = {psum[0], lo_q[WeightW-1:1]};
        wsr_d = {1'b0, wsr_q[WeightW-1:1]};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(WeightW - 1)) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        // convex combination: never negative, never above full scale
        hist_d  = fsum[LevelW-1:0];
        state_d = ST_LUX;
      end
      ST_LUX: begin
        dark_d    = (hist_q <= DarkMax);
        bright_d  = (hist_q >= BrightMin);
        div_start = 1'b1;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        if (!div_busy && out_free) begin
          out_valid_d = 1'b1;
          out_level_d = hist_q;
          if (dark_q) begin
            out_lux_d = '0;
          end else if (bright_q || div_quo > LuxMax) begin
            out_lux_d = LuxMax;
          end else begin
            out_lux_d = div_quo;
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      weight_q    <= WeightReset;
      hist_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      weight_q    <= weight_d;
      hist_q      <= hist_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wsr_q       <= wsr_d;
    diff_q      <= diff_d;
    hi_q        <= hi_d;
    lo_q        <= lo_d;
    dark_q      <= dark_d;
    bright_q    <= bright_d;
    out_level_q <= out_level_d;
    out_lux_q   <= out_lux_d;
  end

  assign cfg_ready_o      = 1'b1;
  assign out_valid_o      = out_valid_q;
  assign filtered_level_o = out_level_q;
  assign light_lux_o      = out_lux_q;

endmodule

`default_nettype wire

// ----- bench/tb_ewma_light_sensor_conditioner.sv -----
// Self-checking bench for ewma_light_sensor_conditioner: predicts the EWMA level and lux
// estimate of each sample beat and checks every result beat in order.
// Depends on elsc_pkg and the conditioner RTL.
`timescale 1ns / 100ps

module tb_ewma_light_sensor_conditioner;

  localparam int unsigned SmpW = elsc_pkg::SampleW;
  localparam int unsigned WtW  = elsc_pkg::WeightW;
  localparam int unsigned LvlW = elsc_pkg::LevelW;
  localparam int unsigned LxW  = elsc_pkg::LuxW;

  localparam int          LongHold    = 600;
  localparam int          SettleCyc   = 40;   // a little over the conditioner latency
  localparam int          RandPhases  = 13;
  localparam int          PhaseItems  = 125;
  localparam longint      HalfScale2x = 64'd1048320;  // 4095 << 8
  localparam longint      BrightEdge  = 64'd104832000; // 409500 * 256
  localparam longint      LuxCoef     = 64'd10000000;
  localparam longint      LuxCeil     = 64'd100000;

  typedef struct packed {
    logic [LvlW-1:0] level;
    logic [LxW-1:0]  lux;
  } lux_reading_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic            cfg_valid = 1'b0;
  logic [WtW-1:0]  cfg_data = '0;
  logic            cfg_ready;
  logic            in_valid = 1'b0;
  logic [SmpW-1:0] adc = '0;
  logic            in_stall;
  logic            out_valid;
  logic            out_stall = 1'b0;
  logic [LvlW-1:0] level_o;
  logic [LxW-1:0]  lux_o;

  logic [SmpW-1:0] sample_backlog[$];
  lux_reading_t    pending_readings[$];

  logic [WtW-1:0]  model_weight = elsc_pkg::WeightReset;
  logic [LvlW-1:0] model_level = '0;

  int  fault_cnt = 0;
  int  send_wait = 0;
  int  stall_left = 0;
  int  hold_req = 0;
  int  hold_seen = 0;
  bit  send_idle = 1'b1;
  bit  recv_idle = 1'b1;

  ewma_light_sensor_conditioner dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .adc_sample_i    (adc),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .filtered_level_o(level_o),
    .light_lux_o     (lux_o)
  );

  always #2 clk = ~clk;

  function automatic lux_reading_t ewma_lux_predict(input logic [SmpW-1:0] x,
                                                    input logic [WtW-1:0] w,
                                                    input logic [LvlW-1:0] prev);
    longint unsigned acc;
    longint unsigned f;
    longint unsigned q;
    lux_reading_t    r;
    acc = longint'(w) * (longint'(x) << 8) + (64'd65536 - longint'(w)) * longint'(prev)
          + 64'd32768;
    f = acc >> 16;
    r.level = f[LvlW-1:0];
    f = longint'(r.level);
    // dark side of half scale also covers f = 0
    if (2 * f <= HalfScale2x) begin
      r.lux = '0;
    end else if (101 * f >= BrightEdge) begin
      r.lux = LxW'(LuxCeil);
    end else begin
      q = (LuxCoef * (2 * f - HalfScale2x)) / (64'd99 * f);
      r.lux = (q > LuxCeil) ? LxW'(LuxCeil) : q[LxW-1:0];
    end
    return r;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 20);
    return $urandom_range(40, 120);
  endfunction

  function automatic void log_fault(input string msg);
    if (fault_cnt < 10) $display("[%0t] ERROR %s", $realtime, msg);
    fault_cnt++;
  endfunction

  // sample driver
  always @(posedge clk) begin : drive_p
    logic            nxt_valid;
    logic [SmpW-1:0] nxt_smp;
    nxt_valid = in_valid;
    nxt_smp   = adc;
    if (!rst_n) begin
      nxt_valid = 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        pending_readings.push_back(ewma_lux_predict(adc, model_weight, model_level));
        model_level = pending_readings[$].level;
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (send_wait > 0) begin
          send_wait--;
        end else if (sample_backlog.size() > 0) begin
          nxt_smp   = sample_backlog.pop_front();
          nxt_valid = 1'b1;
          if (send_idle && $urandom_range(0, 2) == 0) send_wait = gap_len();
        end
      end
    end
    in_valid <= nxt_valid;
    adc      <= nxt_smp;
  end

  // receiver back-pressure; a hold request forces one long stretch
  always @(posedge clk) begin : stall_p
    if (hold_seen != hold_req) begin
      hold_seen  = hold_req;
      stall_left = LongHold;
    end else if (stall_left == 0 && recv_idle && $urandom_range(0, 3) == 0) begin
      stall_left = gap_len();
    end
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // result monitor
  always @(posedge clk) begin : check_p
    lux_reading_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_readings.size() == 0) begin
        log_fault($sformatf("unexpected beat level=%0d lux=%0d", level_o, lux_o));
      end else begin
        want = pending_readings.pop_front();
        if (want.level !== level_o)
          log_fault($sformatf("filtered_level exp=%0d got=%0d", want.level, level_o));
        if (want.lux !== lux_o)
          log_fault($sformatf("light_lux exp=%0d got=%0d (level %0d)", want.lux, lux_o,
                              want.level));
      end
    end
  end

  task automatic wait_idle();
    while (sample_backlog.size() != 0 || in_valid || pending_readings.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_weight(input logic [WtW-1:0] w);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= w;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid    <= 1'b0;
    model_weight = w;
  endtask

  initial begin : stim_p
    int unsigned dir_rst[9]  = '{0, 4095, 4095, 4095, 4095, 2048, 1, 2730, 0};
    int unsigned dir_full[6] = '{4095, 4095, 0, 3000, 0, 0};
    int unsigned dir_half[4] = '{4095, 4095, 0, 2047};
    int unsigned dir_zero[3] = '{4095, 0, 1234};
    logic [WtW-1:0] w;
    int tgt;
    int v;
    int r;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // reset weight, then saturating weight (history flushed to zero by the two zeros),
    // then one half so that full scale from zero lands exactly on half scale, then weight zero
    foreach (dir_rst[i]) sample_backlog.push_back(SmpW'(dir_rst[i]));
    wait_idle();
    write_weight(16'hFFFF);
    foreach (dir_full[i]) sample_backlog.push_back(SmpW'(dir_full[i]));
    wait_idle();
    write_weight(16'h8000);
    foreach (dir_half[i]) sample_backlog.push_back(SmpW'(dir_half[i]));
    wait_idle();
    write_weight(16'h0000);
    foreach (dir_zero[i]) sample_backlog.push_back(SmpW'(dir_zero[i]));
    wait_idle();

    tgt = 2048;
    for (int ph = 0; ph < RandPhases; ph++) begin
      case (ph)
        0:       w = 16'hFFFF;
        1:       w = 16'd1;
        2:       w = elsc_pkg::WeightReset;
        4:       w = 16'h0000;
        6:       w = 16'hFFFE;
        8:       w = 16'h8000;
        default: w = WtW'($urandom_range(0, 65535));
      endcase
      send_idle = (ph % 3 != 1) && (ph != 2);
      recv_idle = (ph % 4 != 3) && (ph != 2);
      write_weight(w);
      for (int k = 0; k < PhaseItems; k++) begin
        // slowly moving light level with noise, some jumps to random levels and to the rails
        r = $urandom_range(0, 19);
        if (r == 0) tgt = $urandom_range(0, 4095);
        else if (r == 1) tgt = $urandom_range(0, 1) ? 4095 : 0;
        v = tgt + int'($urandom_range(0, 128)) - 64;
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
        if ($urandom_range(0, 9) == 0) v = $urandom_range(0, 4095);
        sample_backlog.push_back(SmpW'(v));
      end
      if (ph == 2) begin
        // sender keeps offering while the output is held off
        repeat (2) @(posedge clk);
        hold_req <= hold_req + 1;
      end
      wait_idle();
    end

    repeat (SettleCyc) @(posedge clk);
    if (pending_readings.size() != 0)
      log_fault($sformatf("%0d results never arrived", pending_readings.size()));
    if (fault_cnt == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  initial begin : watchdog_p
    #6000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
